>>> src/char_lcd_nibble_sequencer_macros.svh
// Assertion macros for the character LCD nibble sequencer.
// Used by the top level only; needs no package.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

// same-cycle implication under reset
`define LCDNS_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication under reset
`define LCDNS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

>>> src/lcdns_pkg.sv
// Shared types, constants and functions of the character LCD nibble sequencer.
// No dependencies.
package lcdns_pkg;

    localparam int WAIT_W = 22;
    localparam logic [3:0] INIT_LAST_STEP = 4'd8;

    localparam logic [WAIT_W-1:0] ENABLE_PULSE_RESET = 22'd2000;
    localparam logic [WAIT_W-1:0] SHORT_WAIT_RESET   = 22'd50000;
    localparam logic [WAIT_W-1:0] LONG_WAIT_RESET    = 22'd300000;
    localparam logic [WAIT_W-1:0] POWER_ON_RESET     = 22'd3000000;

    localparam logic [7:0] CMD_CLEAR_DISPLAY = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM     = 8'h40;
    localparam logic [6:0] LINE2_OFFSET      = 7'h40;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_CURSOR = 3'd2,
        CMD_PRINT  = 3'd3,
        CMD_GLYPH  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE = 2'd0,
        CFG_SHORT_WAIT   = 2'd1,
        CFG_LONG_WAIT    = 2'd2,
        CFG_POWER_ON     = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        KIND_BYTES = 1'b0,
        KIND_INIT  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        EXTRA_NONE  = 2'd0,
        EXTRA_SHORT = 2'd1,
        EXTRA_LONG  = 2'd2
    } extra_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [WAIT_W-1:0] enable_pulse_wait;
        logic [WAIT_W-1:0] short_command_wait;
        logic [WAIT_W-1:0] long_command_wait;
        logic [WAIT_W-1:0] power_on_wait;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic       two_bytes;
        logic [7:0] byte0;
        logic       rs0;
        logic [7:0] byte1;
        logic       rs1;
        extra_t     extra;
    } desc_t;

    typedef struct packed {
        logic       nib_only;
        logic [7:0] data;
        extra_t     extra;
    } init_step_t;

    function automatic init_step_t init_step(input logic [3:0] idx);
        init_step_t s;
        s.nib_only = 1'b0;
        s.data     = 8'h00;
        s.extra    = EXTRA_SHORT;
        case (idx)
            4'd0:
            begin
                s.nib_only = 1'b1;
                s.data     = 8'h30;
                s.extra    = EXTRA_LONG;
            end
            4'd1, 4'd2:
            begin
                s.nib_only = 1'b1;
                s.data     = 8'h30;
            end
            4'd3:
            begin
                s.nib_only = 1'b1;
                s.data     = 8'h20;
            end
            4'd4:    s.data = 8'h28;
            4'd5:    s.data = 8'h08;
            4'd6:
            begin
                s.data  = 8'h01;
                s.extra = EXTRA_LONG;
            end
            4'd7:    s.data = 8'h06;
            4'd8:    s.data = 8'h0C;
            default: s.data = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [WAIT_W-1:0] sat_add(input logic [WAIT_W-1:0] a,
                                                  input logic [WAIT_W-1:0] b);
        logic [WAIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WAIT_W] ? {WAIT_W{1'b1}} : s[WAIT_W-1:0];
    endfunction

endpackage

>>> src/lcdns_front.sv
// Front end: accepts requests, drops unused codes and turns each into a word descriptor.
// Depends on lcdns_pkg.
module lcdns_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          command,
    input  logic                line_select,
    input  logic [5:0]          column,
    input  logic [7:0]          char_code,
    input  logic [2:0]          glyph_slot,
    input  logic [2:0]          glyph_row_index,
    input  logic [7:0]          glyph_bits,
    output logic                push,
    output lcdns_pkg::desc_t    push_desc,
    input  logic                q_ready
);

    logic             valid_reg;
    logic             valid_next;
    lcdns_pkg::desc_t desc_reg;
    lcdns_pkg::desc_t desc_next;
    logic             accept;
    logic             cmd_ok;
    logic [6:0]       addr;

    assign in_stall  = valid_reg && !q_ready;
    assign accept    = in_valid && !in_stall;
    assign push      = valid_reg && q_ready;
    assign push_desc = desc_reg;
    assign addr      = (line_select ? lcdns_pkg::LINE2_OFFSET : 7'h00) + {1'b0, column};

    always_comb
    begin
        cmd_ok              = 1'b1;
        desc_next.kind      = lcdns_pkg::KIND_BYTES;
        desc_next.two_bytes = 1'b0;
        desc_next.byte0     = {2'b00, lcdns_pkg::CMD_SET_CGRAM[7:6] ^ 2'b00,
                               glyph_slot, 1'b0} & 8'h00;
        desc_next.rs0       = 1'b0;
        desc_next.byte1     = 8'h00;
        desc_next.rs1       = 1'b0;
        desc_next.extra     = lcdns_pkg::EXTRA_NONE;
        case (lcdns_pkg::cmd_t'(command))
            lcdns_pkg::CMD_INIT:
            begin
                desc_next.kind  = lcdns_pkg::KIND_INIT;
            end
            lcdns_pkg::CMD_CLEAR:
            begin
                desc_next.byte1 = lcdns_pkg::CMD_CLEAR_DISPLAY;
                desc_next.extra = lcdns_pkg::EXTRA_LONG;
            end
            lcdns_pkg::CMD_CURSOR:
            begin
                desc_next.byte1 = lcdns_pkg::CMD_SET_DDRAM | {1'b0, addr};
                desc_next.extra = lcdns_pkg::EXTRA_SHORT;
            end
            lcdns_pkg::CMD_PRINT:
            begin
                desc_next.byte1 = char_code;
                desc_next.rs1   = 1'b1;
            end
            lcdns_pkg::CMD_GLYPH:
            begin
                desc_next.two_bytes = (glyph_row_index == 3'd0);
                desc_next.byte0     = lcdns_pkg::CMD_SET_CGRAM | {2'b00, glyph_slot, 3'b000};
                desc_next.byte1     = {3'b000, glyph_bits[4:0]};
                desc_next.rs1       = 1'b1;
            end
            default: cmd_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept && cmd_ok)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd_ok)
        begin
            desc_reg <= desc_next;
        end
    end

endmodule

>>> src/lcdns_queue.sv
// Short descriptor queue between front end and write sequencer.
// Depends on lcdns_pkg.
module lcdns_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcdns_pkg::desc_t push_desc,
    output logic             q_ready,
    input  logic             pop,
    output logic             q_valid,
    output lcdns_pkg::desc_t q_desc
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lcdns_pkg::desc_t entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign q_ready = (count_reg != CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_desc  = entry_reg[rd_ptr_reg];
    assign do_push = push && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> src/lcdns_back.sv
// Write sequencer: walks one descriptor as nibble pairs and registers each expander word.
// Depends on lcdns_pkg.
module lcdns_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcdns_pkg::cfg_t               cfg,
    input  logic                          q_valid,
    input  lcdns_pkg::desc_t              q_desc,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    expander_byte,
    output logic [lcdns_pkg::WAIT_W-1:0]  wait_before,
    output logic [lcdns_pkg::WAIT_W-1:0]  wait_after,
    output logic                          last
);

    lcdns_pkg::back_state_t state_reg;
    lcdns_pkg::back_state_t state_next;
    lcdns_pkg::desc_t       desc_reg;
    lcdns_pkg::desc_t       desc_next;
    logic [3:0]             step_reg;
    logic [3:0]             step_next;
    logic                   nib_reg;
    logic                   nib_next;
    logic                   en_low_reg;
    logic                   en_low_next;
    logic                   first_reg;
    logic                   first_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             byte_reg;
    logic [7:0]             byte_next;
    logic [lcdns_pkg::WAIT_W-1:0] wb_reg;
    logic [lcdns_pkg::WAIT_W-1:0] wb_next;
    logic [lcdns_pkg::WAIT_W-1:0] wa_reg;
    logic [lcdns_pkg::WAIT_W-1:0] wa_next;
    logic                   last_reg;
    logic                   last_next;

    lcdns_pkg::init_step_t  init_info;
    logic                   nib_only;
    logic [7:0]             data;
    logic                   rs;
    lcdns_pkg::extra_t      extra;
    logic                   last_step;
    logic [3:0]             nibble;
    logic                   step_done;
    logic                   final_write;
    logic [lcdns_pkg::WAIT_W-1:0] extra_val;
    logic                   advance;
    logic                   emit;

    assign out_valid     = out_valid_reg;
    assign expander_byte = byte_reg;
    assign wait_before   = wb_reg;
    assign wait_after    = wa_reg;
    assign last          = last_reg;

    assign init_info = lcdns_pkg::init_step(step_reg);
    assign advance   = !out_valid_reg || !out_stall;
    assign emit      = (state_reg == lcdns_pkg::BK_RUN) && advance;

    always_comb
    begin
        if (desc_reg.kind == lcdns_pkg::KIND_INIT)
        begin
            nib_only  = init_info.nib_only;
            data      = init_info.data;
            rs        = 1'b0;
            extra     = init_info.extra;
            last_step = (step_reg == lcdns_pkg::INIT_LAST_STEP);
        end
        else if (desc_reg.two_bytes && step_reg == 4'd0)
        begin
            nib_only  = 1'b0;
            data      = desc_reg.byte0;
            rs        = desc_reg.rs0;
            extra     = lcdns_pkg::EXTRA_NONE;
            last_step = 1'b0;
        end
        else
        begin
            nib_only  = 1'b0;
            data      = desc_reg.byte1;
            rs        = desc_reg.rs1;
            extra     = desc_reg.extra;
            last_step = 1'b1;
        end
    end

    always_comb
    begin
        case (extra)
            lcdns_pkg::EXTRA_SHORT: extra_val = cfg.short_command_wait;
            lcdns_pkg::EXTRA_LONG:  extra_val = cfg.long_command_wait;
            default:                extra_val = '0;
        endcase
    end

    assign nibble      = nib_reg ? data[3:0] : data[7:4];
    assign step_done   = en_low_reg && (nib_only || nib_reg);
    assign final_write = step_done && last_step;
    assign pop         = q_valid && ((state_reg == lcdns_pkg::BK_IDLE) ||
                                     (emit && final_write));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcdns_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = lcdns_pkg::BK_RUN;
                end
            end
            lcdns_pkg::BK_RUN:
            begin
                if (emit && final_write && !q_valid)
                begin
                    state_next = lcdns_pkg::BK_IDLE;
                end
            end
            default: state_next = lcdns_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        desc_next      = desc_reg;
        step_next      = step_reg;
        nib_next       = nib_reg;
        en_low_next    = en_low_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        wb_next        = wb_reg;
        wa_next        = wa_reg;
        last_next      = last_reg;

        if (emit)
        begin
            out_valid_next = 1'b1;
            byte_next      = {nibble, 1'b1, !en_low_reg, 1'b0, rs};
            wb_next        = first_reg ? cfg.power_on_wait : '0;
            wa_next        = step_done ? lcdns_pkg::sat_add(cfg.enable_pulse_wait, extra_val)
                                       : cfg.enable_pulse_wait;
            last_next      = final_write;
            first_next     = 1'b0;
            if (en_low_reg)
            begin
                en_low_next = 1'b0;
                if (step_done)
                begin
                    step_next = step_reg + 1'b1;
                    nib_next  = 1'b0;
                end
                else
                begin
                    nib_next  = 1'b1;
                end
            end
            else
            begin
                en_low_next = 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            desc_next   = q_desc;
            step_next   = '0;
            nib_next    = 1'b0;
            en_low_next = 1'b0;
            first_next  = (q_desc.kind == lcdns_pkg::KIND_INIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdns_pkg::BK_IDLE;
            step_reg      <= '0;
            nib_reg       <= 1'b0;
            en_low_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nib_reg       <= nib_next;
            en_low_reg    <= en_low_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        byte_reg <= byte_next;
        wb_reg   <= wb_next;
        wa_reg   <= wa_next;
        last_reg <= last_next;
    end

endmodule

>>> src/char_lcd_nibble_sequencer.sv
// From idle, a request goes through the front-end, queue, descriptor and output registers.
// Throughput: one word per cycle, unless stalled, from the sequencer's single output register;
//   init gives 28 words, clear, set cursor and print 4, glyph row 4 or 8 (row 0).
// New requests are taken while a run is still going, up to the queue depth plus one.
// Reset: asynchronous, clears queue and sequencer, loads wait registers with defaults.
// Depends on lcdns_pkg, lcdns_front, lcdns_queue, lcdns_back and the macros header.
`include "char_lcd_nibble_sequencer_macros.svh"

module char_lcd_nibble_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [lcdns_pkg::WAIT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    command,
    input  logic                          line_select,
    input  logic [5:0]                    column,
    input  logic [7:0]                    char_code,
    input  logic [2:0]                    glyph_slot,
    input  logic [2:0]                    glyph_row_index,
    input  logic [7:0]                    glyph_bits,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    expander_byte,
    output logic [lcdns_pkg::WAIT_W-1:0]  wait_before,
    output logic [lcdns_pkg::WAIT_W-1:0]  wait_after,
    output logic                          last
);

    lcdns_pkg::cfg_t  cfg_reg;
    lcdns_pkg::cfg_t  cfg_next;
    logic             push;
    lcdns_pkg::desc_t push_desc;
    logic             q_ready;
    logic             pop;
    logic             q_valid;
    lcdns_pkg::desc_t q_desc;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (lcdns_pkg::cfg_idx_t'(cfg_index))
                lcdns_pkg::CFG_ENABLE_PULSE: cfg_next.enable_pulse_wait  = cfg_data;
                lcdns_pkg::CFG_SHORT_WAIT:   cfg_next.short_command_wait = cfg_data;
                lcdns_pkg::CFG_LONG_WAIT:    cfg_next.long_command_wait  = cfg_data;
                lcdns_pkg::CFG_POWER_ON:     cfg_next.power_on_wait      = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_pulse_wait  <= lcdns_pkg::ENABLE_PULSE_RESET;
            cfg_reg.short_command_wait <= lcdns_pkg::SHORT_WAIT_RESET;
            cfg_reg.long_command_wait  <= lcdns_pkg::LONG_WAIT_RESET;
            cfg_reg.power_on_wait      <= lcdns_pkg::POWER_ON_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcdns_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .line_select     (line_select),
        .column          (column),
        .char_code       (char_code),
        .glyph_slot      (glyph_slot),
        .glyph_row_index (glyph_row_index),
        .glyph_bits      (glyph_bits),
        .push            (push),
        .push_desc       (push_desc),
        .q_ready         (q_ready)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_desc    (q_desc)
    );

    lcdns_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_desc        (q_desc),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .expander_byte (expander_byte),
        .wait_before   (wait_before),
        .wait_after    (wait_after),
        .last          (last)
    );

    `LCDNS_ASSERT_NOW(a_stall_needs_full_queue, clk, rst_n, in_stall, !q_ready, "stall without full queue")
    `LCDNS_ASSERT_NOW(a_enable_high_not_last, clk, rst_n, out_valid && expander_byte[2], !last, "enable-high word marked last")
    `LCDNS_ASSERT_NOW(a_pop_only_when_valid, clk, rst_n, pop, q_valid, "pop from empty queue")
    `LCDNS_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push && q_ready && !pop, q_valid, "pushed word missing from queue")

endmodule

>>> dv/char_lcd_nibble_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_nibble_sequencer: directed and random LCD requests
// under several wait settings, with expander words predicted and checked field by field.
// Depends on lcdns_pkg and the char_lcd_nibble_sequencer RTL.

typedef struct packed {
    logic [7:0]                   data;
    logic [lcdns_pkg::WAIT_W-1:0] lead;
    logic [lcdns_pkg::WAIT_W-1:0] after;
    logic                         last;
} lcd_write_t;

class lcd_write_scoreboard;
    localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
    localparam logic [7:0] ENABLE_BIT    = 8'h04;
    localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
    localparam logic [7:0] WAKE_UP       = 8'h30;
    localparam logic [7:0] FOUR_BIT_MODE = 8'h20;
    localparam logic [7:0] FUNCTION_SET  = 8'h28;
    localparam logic [7:0] DISPLAY_OFF   = 8'h08;
    localparam logic [7:0] ENTRY_MODE    = 8'h06;
    localparam logic [7:0] DISPLAY_ON    = 8'h0C;

    logic [lcdns_pkg::WAIT_W-1:0] pulse_wait;
    logic [lcdns_pkg::WAIT_W-1:0] short_wait;
    logic [lcdns_pkg::WAIT_W-1:0] long_wait;
    logic [lcdns_pkg::WAIT_W-1:0] power_wait;
    logic [lcdns_pkg::WAIT_W-1:0] first_wait;
    lcd_write_t                   run[$];
    lcd_write_t                   expected_writes[$];
    int                           errors;

    function new();
        pulse_wait = lcdns_pkg::ENABLE_PULSE_RESET;
        short_wait = lcdns_pkg::SHORT_WAIT_RESET;
        long_wait  = lcdns_pkg::LONG_WAIT_RESET;
        power_wait = lcdns_pkg::POWER_ON_RESET;
        first_wait = '0;
        errors     = 0;
    endfunction

    function void set_register(lcdns_pkg::cfg_idx_t idx, logic [lcdns_pkg::WAIT_W-1:0] value);
        case (idx)
            lcdns_pkg::CFG_ENABLE_PULSE: pulse_wait = value;
            lcdns_pkg::CFG_SHORT_WAIT:   short_wait = value;
            lcdns_pkg::CFG_LONG_WAIT:    long_wait  = value;
            default:                     power_wait = value;
        endcase
    endfunction

    function logic [lcdns_pkg::WAIT_W-1:0] clip_sum(logic [lcdns_pkg::WAIT_W-1:0] a,
                                                    logic [lcdns_pkg::WAIT_W-1:0] b);
        logic [lcdns_pkg::WAIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[lcdns_pkg::WAIT_W] ? '1 : s[lcdns_pkg::WAIT_W-1:0];
    endfunction

    function void push_write(logic [7:0] data, logic [lcdns_pkg::WAIT_W-1:0] after);
        lcd_write_t w;
        w.data     = data;
        w.lead     = first_wait;
        w.after    = after;
        w.last     = 1'b0;
        first_wait = '0;
        run.push_back(w);
    endfunction

    function void push_nibble(logic [7:0] nib, logic rs, logic [lcdns_pkg::WAIT_W-1:0] extra);
        logic [7:0] base;
        base = (nib & NIBBLE_MASK) | BACKLIGHT_BIT | {7'b0, rs};
        push_write(base | ENABLE_BIT, pulse_wait);
        push_write(base & ~ENABLE_BIT, clip_sum(pulse_wait, extra));
    endfunction

    function void push_byte(logic [7:0] data, logic rs, logic [lcdns_pkg::WAIT_W-1:0] extra);
        push_nibble(data & NIBBLE_MASK, rs, '0);
        push_nibble({data[3:0], 4'b0}, rs, extra);
    endfunction

    function void note_request(logic [2:0] code, logic line, logic [5:0] col, logic [7:0] ch,
                               logic [2:0] slot, logic [2:0] row, logic [7:0] bits);
        logic [6:0] addr;
        lcd_write_t w;
        run.delete();
        first_wait = '0;
        case (code)
            lcdns_pkg::CMD_INIT:
            begin
                first_wait = power_wait;
                push_nibble(WAKE_UP, 1'b0, long_wait);
                push_nibble(WAKE_UP, 1'b0, short_wait);
                push_nibble(WAKE_UP, 1'b0, short_wait);
                push_nibble(FOUR_BIT_MODE, 1'b0, short_wait);
                push_byte(FUNCTION_SET, 1'b0, short_wait);
                push_byte(DISPLAY_OFF, 1'b0, short_wait);
                push_byte(lcdns_pkg::CMD_CLEAR_DISPLAY, 1'b0, long_wait);
                push_byte(ENTRY_MODE, 1'b0, short_wait);
                push_byte(DISPLAY_ON, 1'b0, short_wait);
            end
            lcdns_pkg::CMD_CLEAR:
            begin
                push_byte(lcdns_pkg::CMD_CLEAR_DISPLAY, 1'b0, long_wait);
            end
            lcdns_pkg::CMD_CURSOR:
            begin
                addr = (line ? lcdns_pkg::LINE2_OFFSET : 7'h00) + {1'b0, col};
                push_byte(lcdns_pkg::CMD_SET_DDRAM | {1'b0, addr}, 1'b0, short_wait);
            end
            lcdns_pkg::CMD_PRINT:
            begin
                push_byte(ch, 1'b1, '0);
            end
            lcdns_pkg::CMD_GLYPH:
            begin
                if (row == 3'd0)
                begin
                    push_byte(lcdns_pkg::CMD_SET_CGRAM | {2'b0, slot, 3'b0}, 1'b0, '0);
                end
                push_byte({3'b0, bits[4:0]}, 1'b1, '0);
            end
            default:
            begin
            end
        endcase
        foreach (run[i])
        begin
            w      = run[i];
            w.last = (i == run.size() - 1);
            expected_writes.push_back(w);
        end
    endfunction

    function void check_write(logic [7:0] data, logic [lcdns_pkg::WAIT_W-1:0] lead,
                              logic [lcdns_pkg::WAIT_W-1:0] after, logic last);
        lcd_write_t w;
        if (expected_writes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word: expected none, actual byte %h", $time, data);
            return;
        end
        w = expected_writes.pop_front();
        if (data !== w.data)
        begin
            errors++;
            $display("%0t: expander_byte expected %h actual %h", $time, w.data, data);
        end
        if (lead !== w.lead)
        begin
            errors++;
            $display("%0t: wait_before expected %0d actual %0d", $time, w.lead, lead);
        end
        if (after !== w.after)
        begin
            errors++;
            $display("%0t: wait_after expected %0d actual %0d", $time, w.after, after);
        end
        if (last !== w.last)
        begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, w.last, last);
        end
    endfunction

    function int pending();
        return expected_writes.size();
    endfunction
endclass

module char_lcd_nibble_sequencer_tb;

    localparam int              HOLD_OFF_CYCLES    = 400;
    localparam int              SETTLE_CYCLES      = 16;
    localparam int              RANDOM_PHASES      = 6;
    localparam int              PHASE_ITEMS        = 80;
    localparam int              TIMEOUT_NS         = 40_000_000;
    localparam logic [2:0]      CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0]      CMD_RESERVED_LAST  = 3'd7;
    localparam logic [lcdns_pkg::WAIT_W-1:0] WAIT_MAX = '1;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [1:0]                   cfg_index;
    logic [lcdns_pkg::WAIT_W-1:0] cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [2:0]                   command;
    logic                         line_select;
    logic [5:0]                   column;
    logic [7:0]                   char_code;
    logic [2:0]                   glyph_slot;
    logic [2:0]                   glyph_row_index;
    logic [7:0]                   glyph_bits;
    logic                         out_valid;
    logic                         out_stall;
    logic [7:0]                   expander_byte;
    logic [lcdns_pkg::WAIT_W-1:0] wait_before;
    logic [lcdns_pkg::WAIT_W-1:0] wait_after;
    logic                         last;

    lcd_write_scoreboard sb;
    int                  hold_off_count = 0;

    char_lcd_nibble_sequencer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .line_select     (line_select),
        .column          (column),
        .char_code       (char_code),
        .glyph_slot      (glyph_slot),
        .glyph_row_index (glyph_row_index),
        .glyph_bits      (glyph_bits),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .expander_byte   (expander_byte),
        .wait_before     (wait_before),
        .wait_after      (wait_after),
        .last            (last)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [lcdns_pkg::WAIT_W-1:0] pick_wait();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return WAIT_MAX;
        else if (r == 1)
            return '0;
        else if (r < 4)
            return lcdns_pkg::WAIT_W'($urandom_range(32'h200000, 32'h3FFFFF));
        else
            return lcdns_pkg::WAIT_W'($urandom_range(0, 32'h3FFFFF));
    endfunction

    task automatic send_request(input logic [2:0] code, input logic line, input logic [5:0] col,
                                input logic [7:0] ch, input logic [2:0] slot,
                                input logic [2:0] row, input logic [7:0] bits);
        @(negedge clk);
        in_valid        = 1'b1;
        command         = code;
        line_select     = line;
        column          = col;
        char_code       = ch;
        glyph_slot      = slot;
        glyph_row_index = row;
        glyph_bits      = bits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(code, line, col, ch, slot, row, bits);
    endtask

    task automatic send_random_request();
        int         r;
        logic [2:0] code;
        logic [2:0] row;
        r   = $urandom_range(0, 99);
        row = 3'($urandom);
        if (r < 8)
            code = lcdns_pkg::CMD_INIT;
        else if (r < 20)
            code = lcdns_pkg::CMD_CLEAR;
        else if (r < 40)
            code = lcdns_pkg::CMD_CURSOR;
        else if (r < 62)
            code = lcdns_pkg::CMD_PRINT;
        else if (r < 90)
            code = lcdns_pkg::CMD_GLYPH;
        else
            code = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        if (code == lcdns_pkg::CMD_GLYPH && $urandom_range(0, 2) == 0)
            row = 3'd0;
        send_request(code, 1'($urandom), 6'($urandom), 8'($urandom), 3'($urandom), row,
                     8'($urandom));
    endtask

    task automatic rest_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid        = 1'b0;
            command         = 3'($urandom);
            line_select     = 1'($urandom);
            column          = 6'($urandom);
            char_code       = 8'($urandom);
            glyph_slot      = 3'($urandom);
            glyph_row_index = 3'($urandom);
            glyph_bits      = 8'($urandom);
            repeat (n - 1)
                @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input lcdns_pkg::cfg_idx_t idx,
                                  input logic [lcdns_pkg::WAIT_W-1:0] value);
        @(negedge clk);
        in_valid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_config(input logic [lcdns_pkg::WAIT_W-1:0] pulse,
                                input logic [lcdns_pkg::WAIT_W-1:0] short_w,
                                input logic [lcdns_pkg::WAIT_W-1:0] long_w,
                                input logic [lcdns_pkg::WAIT_W-1:0] power);
        write_register(lcdns_pkg::CFG_ENABLE_PULSE, pulse);
        write_register(lcdns_pkg::CFG_SHORT_WAIT, short_w);
        write_register(lcdns_pkg::CFG_LONG_WAIT, long_w);
        write_register(lcdns_pkg::CFG_POWER_ON, power);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_write(expander_byte, wait_before, wait_after, last);
    end

    initial
    begin : result_stall_driver
        int stall_left;
        int free_left;
        int hold_off_seen;
        out_stall     = 1'b0;
        stall_left    = 0;
        free_left     = 0;
        hold_off_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_seen != hold_off_count)
            begin
                hold_off_seen = hold_off_count;
                stall_left    = HOLD_OFF_CYCLES;
                free_left     = 0;
            end
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall = 1'b0;
                free_left--;
            end
            else
            begin
                out_stall  = 1'b0;
                stall_left = pick_gap();
                if ($urandom_range(0, 19) == 0)
                    free_left = $urandom_range(50, 150);
                else
                    free_left = $urandom_range(0, 8);
            end
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int         i;
        int         p;
        int         burst_left;
        logic [2:0] code;
        sb              = new();
        burst_left      = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = lcdns_pkg::CFG_ENABLE_PULSE;
        cfg_data        = '0;
        in_valid        = 1'b0;
        command         = lcdns_pkg::CMD_INIT;
        line_select     = 1'b0;
        column          = '0;
        char_code       = '0;
        glyph_slot      = '0;
        glyph_row_index = '0;
        glyph_bits      = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_request(lcdns_pkg::CMD_INIT, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CLEAR, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CURSOR, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CURSOR, 1'b1, 6'd39, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CURSOR, 1'b1, 6'd63, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CURSOR, 1'b0, 6'd63, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_PRINT, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_PRINT, 1'b1, 6'd0, 8'hFF, 3'd7, 3'd7, 8'hFF);
        send_request(lcdns_pkg::CMD_GLYPH, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_GLYPH, 1'b0, 6'd0, 8'h00, 3'd7, 3'd0, 8'hFF);
        send_request(lcdns_pkg::CMD_GLYPH, 1'b0, 6'd0, 8'h00, 3'd5, 3'd7, 8'hE0);
        send_request(lcdns_pkg::CMD_GLYPH, 1'b0, 6'd0, 8'h00, 3'd2, 3'd3, 8'h1F);
        for (code = CMD_RESERVED_FIRST; code != lcdns_pkg::CMD_INIT; code++)
            send_request(code, 1'($urandom), 6'($urandom), 8'($urandom), 3'($urandom),
                         3'($urandom), 8'($urandom));
        send_request(lcdns_pkg::CMD_PRINT, 1'b0, 6'd0, 8'h5A, 3'd0, 3'd0, 8'h00);

        drain_results();
        apply_config(WAIT_MAX, WAIT_MAX, WAIT_MAX, WAIT_MAX);
        send_request(lcdns_pkg::CMD_INIT, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CLEAR, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CURSOR, 1'b1, 6'd39, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_GLYPH, 1'b0, 6'd0, 8'h00, 3'd3, 3'd0, 8'h15);

        drain_results();
        apply_config('0, '0, '0, '0);
        send_request(lcdns_pkg::CMD_INIT, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_CLEAR, 1'b0, 6'd0, 8'h00, 3'd0, 3'd0, 8'h00);
        send_request(lcdns_pkg::CMD_PRINT, 1'b0, 6'd0, 8'h55, 3'd0, 3'd0, 8'h00);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            if (p == 0)
                apply_config(lcdns_pkg::ENABLE_PULSE_RESET, lcdns_pkg::SHORT_WAIT_RESET,
                             lcdns_pkg::LONG_WAIT_RESET, lcdns_pkg::POWER_ON_RESET);
            else if (p == 1)
                apply_config(22'h200000, 22'h1FFFFF, 22'h300000, 22'h3FFFFF);
            else
                apply_config(pick_wait(), pick_wait(), pick_wait(), pick_wait());
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 20)
                begin
                    hold_off_count++;
                    burst_left = 40;
                end
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain_results();
                send_random_request();
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 24) == 0)
                    burst_left = $urandom_range(10, 30);
                else
                    rest_sender(pick_gap());
            end
        end

        drain_results();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
